// ----- rtl/atb_pkg.sv -----
`default_nettype none
package atb_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 19;
  localparam int MS_W       = 16;
  localparam int Q16_W      = 16;
  localparam int RATE_W     = 16;
  localparam int PERIOD_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam int FALLOFF_TARGET_Q16_DEF = 19661;
  localparam int SAMPLE_PERIOD_MS_DEF   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_HO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_MS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd7;

  localparam logic [THR_W-1:0] MIN_THR_RST  = 19'd5120;
  localparam logic [THR_W-1:0] MAX_THR_RST  = 19'd204800;
  localparam logic [THR_W-1:0] STEP_RES_RST = 19'd7680;
  localparam logic [MS_W-1:0]  INIT_HO_RST  = 16'd2000;
  localparam logic [MS_W-1:0]  MASK_HO_RST  = 16'd200;
  localparam logic [MS_W-1:0]  LOST_MS_RST  = 16'd2000;
  localparam logic [Q16_W-1:0] DECAY_RST    = 16'd64881;
  localparam logic [Q16_W-1:0] ALPHA_RST    = 16'd39322;

  // 60000 bpm*ms in Q16.16 over a Q24.8 period gives the rate in Q8.8 bpm.
  localparam logic [PERIOD_W-1:0] RATE_NUM = 32'd3932160000;

  typedef enum logic [2:0] {
    PH_INIT, PH_WAIT, PH_SLOPE, PH_MAYBE, PH_MASK
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_EVAL, SQ_PMUL1, SQ_PMUL2, SQ_PSUM, SQ_LOWER, SQ_LMUL, SQ_LDIV,
    SQ_LWAIT, SQ_LAPPLY, SQ_GMUL, SQ_GAPPLY, SQ_RATE, SQ_RWAIT, SQ_RAPPLY, SQ_FINISH
  } seq_t;

  typedef enum logic [1:0] {MS_SINCE, MS_PERIOD, MS_PEAK, MS_LEVEL} mul_sel_t;
  typedef enum logic {DS_DECAY, DS_RATE} div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     eval;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     period_upd;
    logic     div_start;
    div_sel_t div_sel;
    logic     lin_apply;
    logic     geo_apply;
    logic     rate_apply;
    logic     rate_zero;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic need_lower;
    logic need_period;
    logic lin;
    logic period_nz;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/atb_if.sv -----
`default_nettype none
interface atb_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [atb_pkg::SAMPLE_W-1:0] sample;
  logic        [atb_pkg::TIME_W-1:0]   now_ms;
  modport source (output valid, output sample, output now_ms, input ready);
  modport sink (input valid, input sample, input now_ms, output ready);
endinterface

interface atb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         beat_found;
  logic [atb_pkg::RATE_W-1:0]   rate_bpm;
  logic [atb_pkg::THR_W-1:0]    current_threshold;
  modport source (output valid, output beat_found, output rate_bpm,
                  output current_threshold, input ready);
  modport sink (input valid, input beat_found, input rate_bpm,
                input current_threshold, output ready);
endinterface
`default_nettype wire

// ----- rtl/adaptive_threshold_beat_detector.sv -----
// Adaptive-threshold heartbeat detector.
// Input channel in_ch carries one filtered pulse sample (signed Q12.8) and a
// millisecond timestamp per item. Output channel out_ch returns exactly one
// result per input: beat flag, rate in Q8.8 bpm and the threshold in Q11.8.
// Eight configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user is to write them only while the block is idle, which the block
// itself does not enforce. An index is taken as is and there is no read-back.
// One item is processed at a time. While no period is known the rate needs no
// division, and a geometric decay adds a multiply. Once a period is known the
// rate needs the bit-serial divider on every item; a linear decay adds a
// second division. The result sits in an output register; the next input is
// accepted as soon as the result has been loaded, even if the receiver has
// not yet taken it. If the receiver stalls with a result still held, the
// block finishes the next item and then waits until that register frees.
// Synchronous reset restores the configuration registers to their defaults, the
// detector to its init phase, the threshold to the default minimum; it clears out_valid.
`default_nettype none
module adaptive_threshold_beat_detector #(
  parameter int FALLOFF_TARGET_Q16 = atb_pkg::FALLOFF_TARGET_Q16_DEF,
  parameter int SAMPLE_PERIOD_MS   = atb_pkg::SAMPLE_PERIOD_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  atb_in_if.sink                          in_ch,
  atb_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [atb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import atb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  atb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atb_dp #(
    .FALLOFF_TARGET_Q16 (FALLOFF_TARGET_Q16),
    .SAMPLE_PERIOD_MS   (SAMPLE_PERIOD_MS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we && !rst),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .sample            (in_ch.sample),
    .now_ms            (in_ch.now_ms),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .beat_found        (out_ch.beat_found),
    .rate_bpm          (out_ch.rate_bpm),
    .current_threshold (out_ch.current_threshold)
  );

  // Only one item is in flight: accepting a sample closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  // A new result appears only at the end of an item's processing.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without an item in flight");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid after reset");
endmodule
`default_nettype wire

// ----- rtl/atb_div.sv -----
`default_nettype none
module atb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [atb_pkg::PERIOD_W-1:0]  dividend,
  input  logic [atb_pkg::PERIOD_W-1:0]  divisor,
  output logic [atb_pkg::PERIOD_W-1:0]  quotient,
  output logic                          done
);
  import atb_pkg::*;

  localparam int CNT_W = $clog2(PERIOD_W + 1);

  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] quo;
  logic [PERIOD_W-1:0] dvs;
  logic [PERIOD_W:0]   rem_sh;
  logic                fits;

  assign rem_sh   = {rem, quo[PERIOD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(PERIOD_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, restoring form.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      if (fits) begin
        rem <= PERIOD_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[PERIOD_W-1:0];
      end
      quo <= {quo[PERIOD_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/atb_ctrl.sv -----
`default_nettype none
module atb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  atb_pkg::sts_t sts,
  output atb_pkg::cmd_t cmd
);
  import atb_pkg::*;

  seq_t state;
  seq_t state_next;

  assign in_ready = (state == SQ_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (in_valid && in_ready) state_next = SQ_EVAL;
      end
      SQ_EVAL: begin
        if (sts.need_period) state_next = SQ_PMUL1;
        else if (sts.need_lower) state_next = SQ_LOWER;
        else state_next = SQ_RATE;
      end
      SQ_PMUL1:  state_next = SQ_PMUL2;
      SQ_PMUL2:  state_next = SQ_PSUM;
      SQ_PSUM:   state_next = SQ_RATE;
      SQ_LOWER:  state_next = sts.lin ? SQ_LMUL : SQ_GMUL;
      SQ_LMUL:   state_next = SQ_LDIV;
      SQ_LDIV:   state_next = SQ_LWAIT;
      SQ_LWAIT: begin
        if (sts.div_done) state_next = SQ_LAPPLY;
      end
      SQ_LAPPLY: state_next = SQ_RATE;
      SQ_GMUL:   state_next = SQ_GAPPLY;
      SQ_GAPPLY: state_next = SQ_RATE;
      SQ_RATE:   state_next = sts.period_nz ? SQ_RWAIT : SQ_FINISH;
      SQ_RWAIT: begin
        if (sts.div_done) state_next = SQ_RAPPLY;
      end
      SQ_RAPPLY: state_next = SQ_FINISH;
      SQ_FINISH: begin
        if (sts.out_free) state_next = SQ_IDLE;
      end
      default:   state_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      SQ_IDLE:   cmd.capture = in_valid && in_ready;
      SQ_EVAL:   cmd.eval = 1'b1;
      SQ_PMUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SINCE;
      end
      SQ_PMUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PERIOD;
      end
      SQ_PSUM:   cmd.period_upd = 1'b1;
      SQ_LMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PEAK;
      end
      SQ_LDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DECAY;
      end
      SQ_LAPPLY: cmd.lin_apply = 1'b1;
      SQ_GMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LEVEL;
      end
      SQ_GAPPLY: cmd.geo_apply = 1'b1;
      SQ_RATE: begin
        cmd.div_start = sts.period_nz;
        cmd.div_sel   = DS_RATE;
        cmd.rate_zero = !sts.period_nz;
      end
      SQ_RAPPLY: cmd.rate_apply = 1'b1;
      SQ_FINISH: cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/atb_dp.sv -----
`default_nettype none
module atb_dp #(
  parameter int FALLOFF_TARGET_Q16 = atb_pkg::FALLOFF_TARGET_Q16_DEF,
  parameter int SAMPLE_PERIOD_MS   = atb_pkg::SAMPLE_PERIOD_MS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  atb_pkg::cmd_t                        cmd,
  output atb_pkg::sts_t                        sts,
  input  logic                                 cfg_we,
  input  logic [atb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [atb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [atb_pkg::SAMPLE_W-1:0]  sample,
  input  logic [atb_pkg::TIME_W-1:0]           now_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 beat_found,
  output logic [atb_pkg::RATE_W-1:0]           rate_bpm,
  output logic [atb_pkg::THR_W-1:0]            current_threshold
);
  import atb_pkg::*;

  localparam int FALL_K = (65536 - FALLOFF_TARGET_Q16) * SAMPLE_PERIOD_MS;
  localparam int KW     = $clog2(FALL_K + 1);
  localparam int BW     = (KW > 17) ? KW : 17;
  localparam int PW     = PERIOD_W + BW;
  localparam int SW     = 57;

  // Configuration registers.
  logic [THR_W-1:0] min_thr, max_thr, step_res;
  logic [MS_W-1:0]  init_ho, mask_ho, lost_ms;
  logic [Q16_W-1:0] decay, alpha;

  // Detector state.
  phase_t                     phase, phase_next;
  logic [THR_W-1:0]           level, level_next;
  logic [PERIOD_W-1:0]        period, period_next;
  logic signed [SAMPLE_W-1:0] peak, peak_next;
  logic [TIME_W-1:0]          last_beat, last_beat_next;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]          now_r;
  logic [TIME_W-1:0]          since, since_r;
  logic                       beat_next, beat_r;
  logic                       need_lower, need_period;
  logic [PW-1:0]              prod;
  logic [47:0]                p1;
  logic [RATE_W-1:0]          rate_r;

  logic [THR_W-1:0]           trunc, clamp;
  logic                       s_gt, s_lt, drop;
  logic [PERIOD_W-1:0]        mul_a;
  logic [BW-1:0]              mul_b;
  logic [SW-1:0]              psum;
  logic [PERIOD_W-1:0]        psat;
  logic [PERIOD_W-1:0]        div_dividend, div_q;
  logic                       div_done;
  logic [THR_W-1:0]           lin_diff, lin_level, geo_raw, geo_level;
  logic [RATE_W-1:0]          rate_sat;

  atb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (period),
    .quotient (div_q),
    .done     (div_done)
  );

  assign since = now_r - last_beat;

  // Whole-unit truncation; only used where the sample is at or above a non-negative level.
  assign trunc = {sample_r[THR_W-1:8], 8'b0};
  assign clamp = (trunc > max_thr) ? max_thr : trunc;
  assign s_gt  = sample_r > $signed({1'b0, level});
  assign s_lt  = sample_r < $signed({1'b0, level});
  assign drop  = ($signed({sample_r[SAMPLE_W-1], sample_r}) + $signed({2'b0, step_res}))
                 < $signed({2'b0, level});

  always_comb begin
    phase_next     = phase;
    level_next     = level;
    period_next    = period;
    peak_next      = peak;
    last_beat_next = last_beat;
    beat_next      = 1'b0;
    need_lower     = 1'b0;
    need_period    = 1'b0;
    case (phase)
      PH_INIT: begin
        if (now_r > TIME_W'(init_ho)) phase_next = PH_WAIT;
      end
      PH_WAIT: begin
        if (s_gt) begin
          level_next = clamp;
          phase_next = PH_SLOPE;
        end
        if (since > TIME_W'(lost_ms)) begin
          period_next = '0;
          peak_next   = '0;
        end
        need_lower = 1'b1;
      end
      PH_SLOPE: begin
        if (s_lt) phase_next = PH_MAYBE;
        else level_next = clamp;
      end
      PH_MAYBE: begin
        if (drop) begin
          beat_next      = 1'b1;
          peak_next      = sample_r;
          phase_next     = PH_MASK;
          need_period    = (since != '0);
          last_beat_next = now_r;
        end else begin
          phase_next = PH_SLOPE;
        end
      end
      default: begin
        if (since > TIME_W'(mask_ho)) phase_next = PH_WAIT;
        need_lower = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_SINCE: begin
        mul_a = since_r;
        mul_b = BW'(alpha);
      end
      MS_PERIOD: begin
        mul_a = period;
        mul_b = BW'(17'h10000 - {1'b0, alpha});
      end
      MS_PEAK: begin
        mul_a = PERIOD_W'(peak[THR_W-1:0]);
        mul_b = BW'(FALL_K);
      end
      default: begin
        mul_a = PERIOD_W'(level);
        mul_b = BW'(decay);
      end
    endcase
  end

  // p1 holds alpha*since in Q.16, prod holds (1-alpha)*period in Q.24.
  assign psum = {1'b0, p1, 8'b0} + SW'(prod) + SW'(32768);
  assign psat = (|psum[SW-1:48]) ? '1 : psum[47:16];

  assign div_dividend = (cmd.div_sel == DS_RATE) ? RATE_NUM : PERIOD_W'(prod >> 16);

  assign lin_diff  = level - div_q[THR_W-1:0];
  assign lin_level = ((div_q > PERIOD_W'(level)) || (lin_diff < min_thr)) ? min_thr : lin_diff;
  assign geo_raw   = prod[THR_W+15:16];
  assign geo_level = (geo_raw < min_thr) ? min_thr : geo_raw;
  assign rate_sat  = (|div_q[PERIOD_W-1:RATE_W]) ? '1 : div_q[RATE_W-1:0];

  assign sts.need_lower  = need_lower;
  assign sts.need_period = need_period;
  assign sts.lin         = (peak > 0) && (period != '0);
  assign sts.period_nz   = (period != '0);
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_thr   <= MIN_THR_RST;
      max_thr   <= MAX_THR_RST;
      step_res  <= STEP_RES_RST;
      init_ho   <= INIT_HO_RST;
      mask_ho   <= MASK_HO_RST;
      lost_ms   <= LOST_MS_RST;
      decay     <= DECAY_RST;
      alpha     <= ALPHA_RST;
      phase     <= PH_INIT;
      level     <= MIN_THR_RST;
      period    <= '0;
      peak      <= '0;
      last_beat <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_THR:  min_thr  <= cfg_data;
          CFG_MAX_THR:  max_thr  <= cfg_data;
          CFG_STEP_RES: step_res <= cfg_data;
          CFG_INIT_HO:  init_ho  <= cfg_data[MS_W-1:0];
          CFG_MASK_HO:  mask_ho  <= cfg_data[MS_W-1:0];
          CFG_LOST_MS:  lost_ms  <= cfg_data[MS_W-1:0];
          CFG_DECAY:    decay    <= cfg_data[Q16_W-1:0];
          CFG_ALPHA:    alpha    <= cfg_data[Q16_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        phase     <= phase_next;
        level     <= level_next;
        period    <= period_next;
        peak      <= peak_next;
        last_beat <= last_beat_next;
      end
      if (cmd.period_upd) period <= psat;
      if (cmd.lin_apply) level <= lin_level;
      if (cmd.geo_apply) level <= geo_level;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample;
      now_r    <= now_ms;
    end
    if (cmd.eval) begin
      since_r <= since;
      beat_r  <= beat_next;
    end
    if (cmd.mul_en) begin
      prod <= PW'(mul_a) * PW'(mul_b);
      if (cmd.mul_sel == MS_PERIOD) p1 <= prod[47:0];
    end
    if (cmd.rate_apply) rate_r <= rate_sat;
    if (cmd.rate_zero) rate_r <= '0;
    if (cmd.load_out) begin
      beat_found        <= beat_r;
      rate_bpm          <= rate_r;
      current_threshold <= level;
    end
  end
endmodule
`default_nettype wire
